[rtl/core/sdas_pkg.sv]
package sdas_pkg;

    localparam int STATE_W   = 4;
    localparam int CELL_W    = 5;
    localparam int SYM_ADR_W = 6;
    localparam int CNT_W     = 11;
    localparam int POS_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    localparam logic [CNT_W-1:0] MAX_OUTPUT     = 11'd1024;
    localparam logic [CNT_W-1:0] OUT_LEN_RESET  = 11'd1000;

    localparam logic [2:0] CMD_LOAD_NEXT = 3'd0;
    localparam logic [2:0] CMD_LOAD_LEN  = 3'd1;
    localparam logic [2:0] CMD_LOAD_SYM  = 3'd2;
    localparam logic [2:0] CMD_START     = 3'd3;
    localparam logic [2:0] CMD_STEP      = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_SYMBOL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_LEN   = 2'd2;

    typedef struct packed {
        logic [2:0]         command;
        logic [STATE_W-1:0] state_index;
        logic               char_index;
        logic [STATE_W-1:0] next_state;
        logic [1:0]         resp_length;
        logic               resp_slot;
        logic               resp_symbol;
    } t_in;

    typedef struct packed {
        logic             symbol;
        logic [POS_W-1:0] position;
        logic             last;
        logic             done_res;
    } t_out;

    typedef struct packed {
        logic               we_next;
        logic               we_len;
        logic               we_sym;
        logic [CELL_W-1:0]  addr;
        logic               slot;
        logic [STATE_W-1:0] next_state;
        logic [1:0]         resp_length;
        logic               resp_symbol;
    } t_tbl_wr;

    typedef struct packed {
        logic [STATE_W-1:0] next_state;
        logic [1:0]         resp_length;
        logic               resp_symbol;
    } t_tbl_rd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TABLE,
        ST_EMIT
    } t_state;

endpackage

[rtl/core/sdas_tables.sv]
module sdas_tables (
    input  logic                      i_clk,
    input  sdas_pkg::t_tbl_wr         i_wr,
    input  logic [sdas_pkg::CELL_W-1:0] i_rd_cell,
    input  logic                      i_rd_slot,
    output sdas_pkg::t_tbl_rd         o_rd
);
    import sdas_pkg::*;

    logic [STATE_W-1:0] r_trans [2**CELL_W];
    logic [1:0]         r_len   [2**CELL_W];
    logic               r_sym   [2**SYM_ADR_W];
    logic [STATE_W-1:0] r_rd_next;
    logic [1:0]         r_rd_len;
    logic               r_rd_sym;

    always_ff @(posedge i_clk) begin
        if (i_wr.we_next) begin
            r_trans[i_wr.addr] <= i_wr.next_state;
        end
        r_rd_next <= r_trans[i_rd_cell];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_len) begin
            r_len[i_wr.addr] <= i_wr.resp_length;
        end
        r_rd_len <= r_len[i_rd_cell];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_sym) begin
            r_sym[{i_wr.addr, i_wr.slot}] <= i_wr.resp_symbol;
        end
        r_rd_sym <= r_sym[{i_rd_cell, i_rd_slot}];
    end

    assign o_rd = '{next_state: r_rd_next, resp_length: r_rd_len, resp_symbol: r_rd_sym};

endmodule

[rtl/core/self_driving_automaton_sequencer.sv]
// Table-driven sequencer whose emitted symbols are fed back as its own input.
// Load, start and unused commands give no result. A step command gives exactly
// one result on o_result, marked by a one-cycle o_valid strobe that the receiver
// cannot hold off. For the first step of a run and a step after the run is
// complete, the strobe is in the cycle after acceptance. Every other step moves
// the FSM through ST_TABLE and ST_EMIT, with busy high in both: the feedback
// queue memory read is registered at acceptance, the registered symbol drives a
// read of the response and transition table memories in ST_TABLE, and the end
// of ST_EMIT updates state and writes the new symbol to the queue; the strobe
// follows ST_EMIT, when busy is low again and the next transaction can be
// taken. Configuration writes are taken at any time but are meant for idle
// periods. Table entries must be written before a run uses them.
module self_driving_automaton_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    output logic                             o_busy,
    input  sdas_pkg::t_in                    i_data,
    output logic                             o_valid,
    output sdas_pkg::t_out                   o_result,
    input  logic                             i_cfg_we,
    input  logic [sdas_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [sdas_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import sdas_pkg::*;

    logic [STATE_W-1:0] r_start_state;
    logic               r_first_sym;
    logic [CNT_W-1:0]   r_out_len;
    logic [STATE_W-1:0] r_cur_state;
    logic [CNT_W-1:0]   r_emitted;
    logic [POS_W-1:0]   r_consume;
    logic               r_resp_pos;
    logic               r_q_rd;
    logic               r_valid;
    t_out               r_result;
    t_state             r_fsm;
    t_state             n_fsm;

    logic               r_queue [2**POS_W];

    logic               accept;
    logic               is_step;
    logic               run_done;
    logic               step_first;
    logic               step_done;
    logic               step_walk;
    logic               emit_walk;
    logic               emit_any;
    logic               emit_sym;
    logic [CNT_W-1:0]   limit;
    logic [CNT_W-1:0]   emitted_inc;
    logic [1:0]         eff_len;
    logic [1:0]         pos_inc;
    logic               exhausted;
    t_tbl_wr            tbl_wr;
    t_tbl_rd            tbl_rd;

    sdas_tables u_tables (
        .i_clk     (i_clk),
        .i_wr      (tbl_wr),
        .i_rd_cell ({r_cur_state, r_q_rd}),
        .i_rd_slot (r_resp_pos),
        .o_rd      (tbl_rd)
    );

    always_comb begin
        if (r_out_len == '0) begin
            limit = CNT_W'(1);
        end else if (r_out_len > MAX_OUTPUT) begin
            limit = MAX_OUTPUT;
        end else begin
            limit = r_out_len;
        end
    end

    assign accept      = i_start && !o_busy;
    assign is_step     = accept && (i_data.command == CMD_STEP);
    assign run_done    = r_emitted >= limit;
    assign step_done   = is_step && run_done;
    assign step_first  = is_step && !run_done && (r_emitted == '0);
    assign step_walk   = is_step && !run_done && (r_emitted != '0);
    assign emit_any    = step_first || emit_walk;
    assign emit_sym    = step_first ? r_first_sym : tbl_rd.resp_symbol;
    assign emitted_inc = r_emitted + CNT_W'(1);

    always_comb begin
        unique case (tbl_rd.resp_length)
            2'd0:    eff_len = 2'd1;
            2'd3:    eff_len = 2'd2;
            default: eff_len = tbl_rd.resp_length;
        endcase
    end

    assign pos_inc   = {1'b0, r_resp_pos} + 2'd1;
    assign exhausted = pos_inc >= eff_len;

    always_comb begin
        tbl_wr             = '0;
        tbl_wr.addr        = {i_data.state_index, i_data.char_index};
        tbl_wr.slot        = i_data.resp_slot;
        tbl_wr.next_state  = i_data.next_state;
        tbl_wr.resp_length = i_data.resp_length;
        tbl_wr.resp_symbol = i_data.resp_symbol;
        tbl_wr.we_next     = accept && (i_data.command == CMD_LOAD_NEXT);
        tbl_wr.we_len      = accept && (i_data.command == CMD_LOAD_LEN);
        tbl_wr.we_sym      = accept && (i_data.command == CMD_LOAD_SYM);
    end

    // next state
    always_comb begin
        n_fsm = r_fsm;
        unique case (r_fsm)
            ST_IDLE:  if (step_walk) n_fsm = ST_TABLE;
            ST_TABLE: n_fsm = ST_EMIT;
            ST_EMIT:  n_fsm = ST_IDLE;
            default:  n_fsm = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_busy    = 1'b1;
        emit_walk = 1'b0;
        unique case (r_fsm)
            ST_IDLE:  o_busy = 1'b0;
            ST_TABLE: o_busy = 1'b1;
            ST_EMIT:  emit_walk = 1'b1;
            default:  o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ST_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_state <= '0;
            r_first_sym   <= 1'b0;
            r_out_len     <= OUT_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_STATE:  r_start_state <= i_cfg_data[STATE_W-1:0];
                CFG_FIRST_SYMBOL: r_first_sym   <= i_cfg_data[0];
                CFG_OUTPUT_LEN:   r_out_len     <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_state <= '0;
            r_emitted   <= '0;
            r_consume   <= '0;
            r_resp_pos  <= 1'b0;
        end else if (accept && (i_data.command == CMD_START)) begin
            r_cur_state <= r_start_state;
            r_emitted   <= '0;
            r_consume   <= '0;
            r_resp_pos  <= 1'b0;
        end else begin
            if (emit_any) begin
                r_emitted <= emitted_inc;
            end
            if (emit_walk) begin
                if (exhausted) begin
                    r_resp_pos  <= 1'b0;
                    r_cur_state <= tbl_rd.next_state;
                    r_consume   <= r_consume + POS_W'(1);
                end else begin
                    r_resp_pos  <= pos_inc[0];
                end
            end
        end
    end

    // feedback queue
    always_ff @(posedge i_clk) begin
        if (emit_any) begin
            r_queue[r_emitted[POS_W-1:0]] <= emit_sym;
        end
        r_q_rd <= r_queue[r_consume];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= emit_any || step_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_done) begin
            r_result.symbol   <= 1'b0;
            r_result.position <= '0;
            r_result.last     <= 1'b0;
            r_result.done_res <= 1'b1;
        end else if (emit_any) begin
            r_result.symbol   <= emit_sym;
            r_result.position <= r_emitted[POS_W-1:0];
            r_result.last     <= emitted_inc == limit;
            r_result.done_res <= 1'b0;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_emit_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_EMIT) |=> r_valid)
        else $error("table step did not produce a result");

    a_no_strobe_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ST_TABLE) |-> !r_valid)
        else $error("result strobe while table read pending");

    a_emitted_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_emitted <= MAX_OUTPUT)
        else $error("emitted count beyond queue depth");

    a_consume_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emitted != '0) |-> ({1'b0, r_consume} < r_emitted))
        else $error("queue read would pass the write point");

    a_fresh_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_emitted == '0) |-> ((r_consume == '0) && !r_resp_pos))
        else $error("run counters out of step");

endmodule
